/* rtl/bounded_window_rounded_mean_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the windowed mean block.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_WINDOW_ROUNDED_MEAN_MACROS_SVH
`define BOUNDED_WINDOW_ROUNDED_MEAN_MACROS_SVH

// same-cycle implication
`define BWRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BWRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bwrm_pkg.sv */
// ----------------------------------------------------------------------------
// bwrm_pkg
// Shared constants and types for the windowed rounded mean block.
// ----------------------------------------------------------------------------
package bwrm_pkg;

    localparam int MAX_WINDOW_DEF   = 8;
    localparam int VALUE_BITS_DEF   = 10;
    localparam int WLEN_BITS        = 4;
    localparam int WINDOW_LEN_RESET = 5;
    localparam int PADDR_BITS       = 3;
    localparam int PDATA_BITS       = 32;

    // register index, taken from paddr above the byte offset
    localparam logic [PADDR_BITS-3:0] REG_WINDOW_LEN = '0;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic shift;   // take neighbour's value
        logic load;    // take new sample
    } cell_ctrl_t;

endpackage

/* rtl/bwrm_req_if.sv */
// ----------------------------------------------------------------------------
// bwrm_req_if
// Request channel: insert or remove one sample word.
// ----------------------------------------------------------------------------
interface bwrm_req_if import bwrm_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [VALUE_BITS-1:0] sample_value;

    modport source (output valid, output req_type, output sample_value, input ready);
    modport sink   (input valid, input req_type, input sample_value, output ready);

endinterface

/* rtl/bwrm_res_if.sv */
// ----------------------------------------------------------------------------
// bwrm_res_if
// Result channel: mean, popped value, empty flag and fill count.
// ----------------------------------------------------------------------------
interface bwrm_res_if import bwrm_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = $clog2(MAX_WINDOW_DEF + 1)
) ();

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] mean_value;
    logic [VALUE_BITS-1:0] removed_value;
    logic                  was_empty;
    logic [COUNT_BITS-1:0] held_count;

    modport source (output valid, output mean_value, output removed_value,
                    output was_empty, output held_count, input ready);
    modport sink   (input valid, input mean_value, input removed_value,
                    input was_empty, input held_count, output ready);

endinterface

/* rtl/bwrm_cell.sv */
// ----------------------------------------------------------------------------
// bwrm_cell
// One window slot: holds a sample, shifts toward the oldest end or loads.
// ----------------------------------------------------------------------------
module bwrm_cell import bwrm_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [VALUE_BITS-1:0] up_value,
    input  logic [VALUE_BITS-1:0] load_value,
    output logic [VALUE_BITS-1:0] value
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_value;
        end
        else if (ctrl.shift)
        begin
            value_next = up_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* rtl/bwrm_div.sv */
// ----------------------------------------------------------------------------
// bwrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwrm_div #(
    parameter int NUM_BITS = 15,
    parameter int DEN_BITS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);

    localparam int ITER_BITS = $clog2(NUM_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic [DEN_BITS-1:0]  rem_reg, rem_next;
    logic [DEN_BITS-1:0]  den_reg, den_next;
    logic [NUM_BITS-1:0]  quo_reg, quo_next;

    logic [DEN_BITS:0]    trial;
    logic [DEN_BITS:0]    diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_BITS'(NUM_BITS);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where dividend bits shift out
            quo_next  = {quo_reg[NUM_BITS-2:0], fits};
            rem_next  = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            iter_next = iter_reg - ITER_BITS'(1);
            if (iter_reg == ITER_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/bounded_window_rounded_mean.sv */
// ----------------------------------------------------------------------------
// bounded_window_rounded_mean
// Moving window of samples with a running sum and rounded-half-up mean.
// ----------------------------------------------------------------------------
// One word in, one word out. A remove is registered into the result stage
// directly on acceptance. An insert first evicts the E oldest values (one
// per cycle, usually 0 or 1) in S_EVICT and loads the new word, then passes
// S_START and S_DIV, where the bit-serial divider of length NUM_BITS =
// VALUE_BITS + clog2(MAX_WINDOW) + 2 forms floor((2*sum + n) / (2*n)).
// The window is a row of cells, the oldest value in cell 0; a pop shifts the
// row down one cell. A new word is taken once the previous one has reached
// the output register, which holds its result until the sink takes it.
// window_len sits at byte address 0; 0 acts as 1, values above MAX_WINDOW as
// MAX_WINDOW.
`include "bounded_window_rounded_mean_macros.svh"

module bounded_window_rounded_mean import bwrm_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    bwrm_req_if.sink              req,
    bwrm_res_if.source            res
);

    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = VALUE_BITS + $clog2(MAX_WINDOW);
    localparam int NUM_BITS = SUM_BITS + 2;
    localparam int DEN_BITS = CNT_BITS + 1;
    localparam int CMP_BITS = (CNT_BITS > WLEN_BITS) ? CNT_BITS : WLEN_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVICT = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [WLEN_BITS-1:0]  wlen_reg, wlen_next;
    logic                  out_valid_reg, out_valid_next;

    logic [VALUE_BITS-1:0] sample_reg, sample_next;
    logic [VALUE_BITS-1:0] res_mean_reg, res_mean_next;
    logic [VALUE_BITS-1:0] res_removed_reg, res_removed_next;
    logic                  res_empty_reg, res_empty_next;
    logic [VALUE_BITS-1:0] out_mean_reg, out_mean_next;
    logic [VALUE_BITS-1:0] out_removed_reg, out_removed_next;
    logic                  out_empty_reg, out_empty_next;
    logic [CNT_BITS-1:0]   out_count_reg, out_count_next;

    logic                  accept;
    logic                  cfg_sel;
    logic                  shift_en;
    logic                  load_en;
    logic                  div_start;
    logic                  div_done;
    logic [NUM_BITS-1:0]   div_num;
    logic [DEN_BITS-1:0]   div_den;
    logic [NUM_BITS-1:0]   div_quo;
    logic [CMP_BITS-1:0]   eff_window;
    logic [CMP_BITS-1:0]   wlen_ext;
    logic [CMP_BITS-1:0]   count_ext;
    logic [VALUE_BITS-1:0] cell_value [MAX_WINDOW];

    // configuration port
    assign cfg_sel = (paddr[PADDR_BITS-1:2] == REG_WINDOW_LEN);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? PDATA_BITS'(wlen_reg) : '0;

    always_comb
    begin
        wlen_next = wlen_reg;
        if (psel && penable && pwrite && cfg_sel)
        begin
            wlen_next = pwdata[WLEN_BITS-1:0];
        end
    end

    assign wlen_ext  = CMP_BITS'(wlen_reg);
    assign count_ext = CMP_BITS'(count_reg);

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_window = CMP_BITS'(1);
        end
        else if (wlen_ext > CMP_BITS'(MAX_WINDOW))
        begin
            eff_window = CMP_BITS'(MAX_WINDOW);
        end
        else
        begin
            eff_window = wlen_ext;
        end
    end

    // row of cells, cell 0 holds the oldest value
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        cell_ctrl_t            ctrl;
        logic [VALUE_BITS-1:0] up_value;

        assign ctrl.shift = shift_en;
        assign ctrl.load  = load_en && (count_reg == CNT_BITS'(i));
        if (i == MAX_WINDOW - 1)
        begin : g_top
            assign up_value = '0;
        end
        else
        begin : g_mid
            assign up_value = cell_value[i+1];
        end

        bwrm_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .up_value   (up_value),
            .load_value (sample_reg),
            .value      (cell_value[i])
        );
    end

    // dividend 2*sum + n, divisor 2*n
    assign div_num = NUM_BITS'({sum_reg, 1'b0}) + NUM_BITS'(count_reg);
    assign div_den = {count_reg, 1'b0};

    bwrm_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        sample_next      = sample_reg;
        res_mean_next    = res_mean_reg;
        res_removed_next = res_removed_reg;
        res_empty_next   = res_empty_reg;
        out_valid_next   = out_valid_reg;
        out_mean_next    = out_mean_reg;
        out_removed_next = out_removed_reg;
        out_empty_next   = out_empty_reg;
        out_count_next   = out_count_reg;
        shift_en         = 1'b0;
        load_en          = 1'b0;
        div_start        = 1'b0;

        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = req.sample_value;
                    if (req.req_type == REQ_REMOVE)
                    begin
                        res_mean_next = '0;
                        if (count_reg == '0)
                        begin
                            res_removed_next = '0;
                            res_empty_next   = 1'b1;
                        end
                        else
                        begin
                            res_removed_next = cell_value[0];
                            res_empty_next   = 1'b0;
                            shift_en         = 1'b1;
                            count_next       = count_reg - CNT_BITS'(1);
                            sum_next         = sum_reg - SUM_BITS'(cell_value[0]);
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_EVICT;
                    end
                end
            end
            S_EVICT:
            begin
                // drop oldest words until one slot is free
                if (count_ext >= eff_window)
                begin
                    shift_en   = 1'b1;
                    count_next = count_reg - CNT_BITS'(1);
                    sum_next   = sum_reg - SUM_BITS'(cell_value[0]);
                end
                else
                begin
                    load_en    = 1'b1;
                    count_next = count_reg + CNT_BITS'(1);
                    sum_next   = sum_reg + SUM_BITS'(sample_reg);
                    state_next = S_START;
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_mean_next    = div_quo[VALUE_BITS-1:0];
                    res_removed_next = '0;
                    res_empty_next   = 1'b0;
                    state_next       = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_mean_next    = res_mean_reg;
                    out_removed_next = res_removed_reg;
                    out_empty_next   = res_empty_reg;
                    out_count_next   = count_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            wlen_reg      <= WLEN_BITS'(WINDOW_LEN_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            wlen_reg      <= wlen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg      <= sample_next;
        res_mean_reg    <= res_mean_next;
        res_removed_reg <= res_removed_next;
        res_empty_reg   <= res_empty_next;
        out_mean_reg    <= out_mean_next;
        out_removed_reg <= out_removed_next;
        out_empty_reg   <= out_empty_next;
        out_count_reg   <= out_count_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.mean_value    = out_mean_reg;
    assign res.removed_value = out_removed_reg;
    assign res.was_empty     = out_empty_reg;
    assign res.held_count    = out_count_reg;

    `BWRM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_BITS'(MAX_WINDOW), "fill count beyond window store")
    `BWRM_ASSERT_IMP(a_empty_sum, clk, rst_n, count_reg == '0, sum_reg == '0, "running sum not zero on empty window")
    `BWRM_ASSERT_IMP(a_fit_window, clk, rst_n, state_reg == S_START, count_ext <= eff_window, "window overfilled after insert")
    `BWRM_ASSERT_NXT(a_empty_pop, clk, rst_n, accept && req.req_type == REQ_REMOVE && count_reg == '0, state_reg == S_OUT && res_empty_reg && count_reg == '0, "remove on empty window mishandled")

endmodule

/* dv/tb_bounded_window_rounded_mean.sv */
// ----------------------------------------------------------------------------
// tb_bounded_window_rounded_mean
// Self-checking bench for the windowed rounded mean block: a short directed
// table, then randomised insert/remove words over a series of window
// lengths, each result checked in order against a local window predictor.
// ----------------------------------------------------------------------------
module tb_bounded_window_rounded_mean;

    import bwrm_pkg::*;

    localparam int VW             = VALUE_BITS_DEF;
    localparam int CW             = $clog2(MAX_WINDOW_DEF + 1);
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int SHOWN_LIMIT    = 10;
    localparam int RANDOM_PER_SET = 100;
    localparam int NUM_SETS       = 12;

    localparam logic [PADDR_BITS-1:0] ADDR_WINDOW_LEN = {REG_WINDOW_LEN, 2'b00};
    localparam logic [PADDR_BITS-1:0] ADDR_UNUSED     = {~REG_WINDOW_LEN, 2'b00};

    // -1 picks a random length, 0 and 15 probe the clamping
    localparam int SET_WINDOW [NUM_SETS] = '{8, 2, 0, 15, 1, 8, 3, 6, -1, -1, 4, 5};

    typedef struct packed {
        logic [VW-1:0] mean;
        logic [VW-1:0] removed;
        logic          empty;
        logic [CW-1:0] count;
    } window_result_t;

    typedef struct packed {
        logic           req_type;
        logic [VW-1:0]  sample;
        logic           known;
        window_result_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    bwrm_req_if #(.VALUE_BITS(VW)) req_ch ();
    bwrm_res_if #(.VALUE_BITS(VW)) res_ch ();

    bounded_window_rounded_mean i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    // predictor state
    logic [VW-1:0]        held_words [$];
    int                   held_sum;
    logic [WLEN_BITS-1:0] win_len;

    window_result_t pending_results [$];
    stim_row_t      directed_rows [$];
    int             miscompare_count = 0;
    int             cycle_count = 0;
    int             insert_pct = 65;
    bit             idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bounded_window_rounded_mean verification failed");
            $finish;
        end
    end

    function automatic window_result_t apply_request(logic rt, logic [VW-1:0] s);
        window_result_t r;
        int             eff;
        int             n;
        r   = '0;
        eff = win_len;
        if (eff == 0)
            eff = 1;
        if (eff > MAX_WINDOW_DEF)
            eff = MAX_WINDOW_DEF;
        if (rt == REQ_INSERT)
        begin
            // a shrunk window may need several evictions before the push
            while (held_words.size() >= eff && held_words.size() > 0)
                held_sum -= held_words.pop_front();
            held_words.push_back(s);
            held_sum += s;
            n = held_words.size();
            r.mean = VW'((2 * held_sum + n) / (2 * n));
        end
        else if (held_words.size() == 0)
            r.empty = 1'b1;
        else
        begin
            r.removed = held_words.pop_front();
            held_sum -= r.removed;
        end
        r.count = CW'(held_words.size());
        return r;
    endfunction

    function automatic void add_row(logic rt, logic [VW-1:0] s, logic known,
                                    int mean, int removed, int empty, int count);
        stim_row_t row;
        row.req_type     = rt;
        row.sample       = s;
        row.known        = known;
        row.want.mean    = VW'(mean);
        row.want.removed = VW'(removed);
        row.want.empty   = 1'(empty);
        row.want.count   = CW'(count);
        directed_rows.push_back(row);
    endfunction

    task automatic send_request(logic rt, logic [VW-1:0] s, logic known,
                                window_result_t want);
        int             gap;
        window_result_t r;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= rt;
        req_ch.sample_value <= s;
        do @(posedge clk); while (!req_ch.ready);
        r = apply_request(rt, s);
        pending_results.push_back(known ? want : r);
    endtask

    task automatic send_random_word(logic rt);
        logic [VW-1:0] s;
        case ($urandom_range(0, 7))
            0:       s = '0;
            1:       s = '1;
            default: s = VW'($urandom());
        endcase
        send_request(rt, s, 1'b0, '0);
    endtask

    task automatic write_reg(logic [PADDR_BITS-1:0] addr, logic [PDATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[PADDR_BITS-1:2] == REG_WINDOW_LEN)
            win_len = data[WLEN_BITS-1:0];
    endtask

    task automatic drain(int settle);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic check_result();
        window_result_t got;
        window_result_t want;
        got = {res_ch.mean_value, res_ch.removed_value, res_ch.was_empty,
               res_ch.held_count};
        if (pending_results.size() == 0)
        begin
            if (miscompare_count < SHOWN_LIMIT)
                $display("unexpected result word: mean %0d removed %0d empty %0d count %0d",
                         got.mean, got.removed, got.empty, got.count);
            miscompare_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.mean !== want.mean || got.removed !== want.removed ||
                got.empty !== want.empty || got.count !== want.count)
            begin
                if (miscompare_count < SHOWN_LIMIT)
                    $display("mismatch at cycle %0d: exp mean %0d removed %0d empty %0d count %0d, got mean %0d removed %0d empty %0d count %0d",
                             cycle_count, want.mean, want.removed, want.empty, want.count,
                             got.mean, got.removed, got.empty, got.count);
                miscompare_count++;
            end
        end
    endtask

    // result sink with random back-pressure
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            check_result();
        end
    end

    initial
    begin
        logic [PDATA_BITS-1:0] data;
        int                    wl;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_INSERT;
        req_ch.sample_value <= '0;
        rst_n               <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        held_words.delete();
        held_sum = 0;
        win_len  = WLEN_BITS'(WINDOW_LEN_RESET);

        // directed words under the reset window length of five
        add_row(REQ_REMOVE, 10'h3FF, 1, 0, 0, 1, 0);       // remove on empty
        add_row(REQ_INSERT, 10'h3FF, 1, 1023, 0, 0, 1);
        add_row(REQ_INSERT, 10'h000, 1, 512, 0, 0, 2);     // 511.5 rounds up
        add_row(REQ_REMOVE, 10'h000, 1, 0, 1023, 0, 1);
        add_row(REQ_REMOVE, 10'h155, 1, 0, 0, 0, 0);
        add_row(REQ_REMOVE, 10'h2AA, 1, 0, 0, 1, 0);
        add_row(REQ_INSERT, 10'h000, 1, 0, 0, 0, 1);
        add_row(REQ_INSERT, 10'h001, 1, 1, 0, 0, 2);       // 0.5 rounds up
        repeat (4) add_row(REQ_INSERT, 10'h3FF, 0, 0, 0, 0, 0);
        add_row(REQ_INSERT, 10'h2AA, 0, 0, 0, 0, 0);       // full window evicts
        add_row(REQ_INSERT, 10'h155, 0, 0, 0, 0, 0);
        repeat (5) add_row(REQ_REMOVE, 10'h000, 0, 0, 0, 0, 0);
        add_row(REQ_REMOVE, 10'h3FF, 1, 0, 0, 1, 0);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req_type, directed_rows[i].sample,
                         directed_rows[i].known, directed_rows[i].want);
        drain(8);

        for (int p = 0; p < NUM_SETS; p++)
        begin
            wl = (SET_WINDOW[p] < 0) ? $urandom_range(0, 15) : SET_WINDOW[p];
            data = $urandom();
            data[WLEN_BITS-1:0] = WLEN_BITS'(wl);
            write_reg(ADDR_WINDOW_LEN, data);
            // a write to an unmapped offset must leave the window alone
            if (p % 3 == 2)
                write_reg(ADDR_UNUSED, $urandom());
            @(posedge clk);
            idle_on    = (p % 4 != 1);
            insert_pct = (p == 3) ? 30 : ((p % 2 == 0) ? 65 : 50);
            repeat (RANDOM_PER_SET)
                send_random_word(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT
                                                                        : REQ_REMOVE);
            // leave the window full so the next, possibly shorter, length evicts
            repeat (MAX_WINDOW_DEF)
                send_random_word(REQ_INSERT);
            drain(8);
        end

        drain(SETTLE_CYCLES);
        if (miscompare_count == 0 && pending_results.size() == 0)
            $display("bounded_window_rounded_mean verification clean");
        else
            $display("bounded_window_rounded_mean verification failed");
        $finish;
    end

endmodule
